// File: hdl/pbp_pkg.sv
package pbp_pkg;

   // Pool geometry.
   localparam int NUM_CLASSES = 16;
   localparam int MIN_SHIFT   = 8;
   localparam int POOL_DEPTH  = 64;
   localparam int PTR_BITS    = 48;

   // Fixed field widths of the request and response.
   localparam int SIZE_W       = 24;
   localparam int ALIGN_W      = 25;
   localparam int PTR_FIELD_W  = 48;
   localparam int BUCKET_OUT_W = 4;
   localparam int STATUS_W     = 2;

   // Derived widths.
   localparam int MAX_SHIFT   = MIN_SHIFT + NUM_CLASSES - 1;
   localparam int SHIFT_MAX   = (MIN_SHIFT > SIZE_W) ? MIN_SHIFT : SIZE_W;
   localparam int SHIFT_W     = $clog2(SHIFT_MAX + 1);
   localparam int BUCKET_W    = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
   localparam int HEAD_W      = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
   localparam int CNT_W       = $clog2(POOL_DEPTH + 1);
   localparam int STORE_DEPTH = NUM_CLASSES * POOL_DEPTH;
   localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

   // Depth of the queue between the front end and the execution unit.
   localparam int QUEUE_DEPTH = 2;
   localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Pointers are kept to PTR_BITS bits.
   localparam logic [PTR_FIELD_W-1:0] PTR_MASK = (PTR_BITS >= PTR_FIELD_W) ?
      {PTR_FIELD_W{1'b1}} : PTR_FIELD_W'((64'd1 << PTR_BITS) - 64'd1);

   typedef enum logic {
      FUNC_ALLOC = 1'b0,
      FUNC_FREE  = 1'b1
   } pbp_func_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_TOO_BIG = 2'd1,
      STATUS_DROPPED = 2'd2
   } pbp_status_type;

   // One classified request as it travels from the front end to the back end.
   typedef struct packed {
      pbp_func_type             func;
      logic                     oversize;
      logic [BUCKET_W-1:0]      bucket;
      logic [ALIGN_W-1:0]       aligned;
      logic [PTR_FIELD_W-1:0]   ptr;
   } pbp_item_type;

   // Smallest shift s, at least MIN_SHIFT, with 2^s not below size.
   function automatic logic [SHIFT_W-1:0] round_shift(input logic [SIZE_W-1:0] size);
      logic [SIZE_W-1:0]  m;
      logic [SHIFT_W-1:0] msb;
      m   = (size == '0) ? '0 : size - SIZE_W'(1);
      msb = '0;
      for (int i = 0; i < SIZE_W; i++) begin
         if (m[i]) begin
            msb = SHIFT_W'(i + 1);
         end
      end
      if (int'(msb) < MIN_SHIFT) begin
         msb = SHIFT_W'(MIN_SHIFT);
      end
      return msb;
   endfunction

endpackage

// File: hdl/pow2_bucket_block_pool.sv
// A request is written to the queue, then popped by the execution unit in its access state,
// which does the bucket state and pointer store access; its reply state presents the result
// on rsp_valid. The unit takes no new request until its reply state is over, but a two-entry
// queue lets up to two further requests be taken while one executes.
// Reset clears the bucket heads and counts (all pools empty) and the queue; the pointer
// store is not cleared, since only entries that were pushed are ever read back.
module pow2_bucket_block_pool import pbp_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic                    req_func,
   input  logic [SIZE_W-1:0]       req_req_bytes,
   input  logic [PTR_FIELD_W-1:0]  req_ret_ptr,
   output logic                    rsp_valid,
   output logic [PTR_FIELD_W-1:0]  rsp_blk_ptr,
   output logic                    rsp_from_pool,
   output logic [ALIGN_W-1:0]      rsp_aligned_bytes,
   output logic [BUCKET_OUT_W-1:0] rsp_bucket_num,
   output logic [STATUS_W-1:0]     rsp_status
);

   // The front end rounds each request size to its power-of-two class and
   // decides the bucket and whether the size is legal, all in the cycle of
   // the transfer. The classified request is then parked in the queue.
   logic         push;
   pbp_item_type push_item;

   // Queue state seen by both sides. The front end stalls only when the queue
   // is full, so busy never depends on the execution unit directly.
   logic         queue_full;
   logic         queue_empty;
   logic         pop;
   pbp_item_type head_item;

   pbp_front u_front (
      .start         (start),
      .queue_full    (queue_full),
      .req_func      (req_func),
      .req_req_bytes (req_req_bytes),
      .req_ret_ptr   (req_ret_ptr),
      .busy          (busy),
      .push          (push),
      .item          (push_item)
   );

   pbp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .full      (queue_full),
      .empty     (queue_empty),
      .head_item (head_item)
   );

   // The back end owns the per-bucket FIFO state and the shared pointer store.
   // An allocate pops the oldest pointer of its bucket, a free appends to it,
   // and the result appears in the cycle after the access, once the store read returns.
   pbp_back u_back (
      .clock             (clock),
      .reset             (reset),
      .queue_empty       (queue_empty),
      .item              (head_item),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_blk_ptr       (rsp_blk_ptr),
      .rsp_from_pool     (rsp_from_pool),
      .rsp_aligned_bytes (rsp_aligned_bytes),
      .rsp_bucket_num    (rsp_bucket_num),
      .rsp_status        (rsp_status)
   );

endmodule

// File: hdl/pbp_ram.sv
module pbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

// File: hdl/pbp_front.sv
module pbp_front import pbp_pkg::*; (
   input  logic                   start,
   input  logic                   queue_full,
   input  logic                   req_func,
   input  logic [SIZE_W-1:0]      req_req_bytes,
   input  logic [PTR_FIELD_W-1:0] req_ret_ptr,
   output logic                   busy,
   output logic                   push,
   output pbp_item_type           item
);

   logic [SHIFT_W-1:0] shift;

   // Round the size up to its power-of-two class and tag the bucket.
   always_comb begin
      shift         = round_shift(req_req_bytes);
      item.func     = pbp_func_type'(req_func);
      item.oversize = (int'(shift) > MAX_SHIFT);
      item.bucket   = item.oversize ? '0 : BUCKET_W'(int'(shift) - MIN_SHIFT);
      item.aligned  = ALIGN_W'(1) << shift;
      item.ptr      = req_ret_ptr & PTR_MASK;
   end

   assign busy = queue_full;
   assign push = start && !queue_full;

endmodule

// File: hdl/pbp_queue.sv
module pbp_queue import pbp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  pbp_item_type push_item,
   input  logic         pop,
   output logic         full,
   output logic         empty,
   output pbp_item_type head_item
);

   pbp_item_type       slot_ff [QUEUE_DEPTH];
   logic [QIDX_W-1:0]  wr_ff, wr_in;
   logic [QIDX_W-1:0]  rd_ff, rd_in;
   logic [QCNT_W-1:0]  cnt_ff, cnt_in;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (int'(wr_ff) == QUEUE_DEPTH - 1) ? '0 : wr_ff + QIDX_W'(1);
      end
      if (pop) begin
         rd_in = (int'(rd_ff) == QUEUE_DEPTH - 1) ? '0 : rd_ff + QIDX_W'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_item;
      end
   end

   assign full      = (int'(cnt_ff) == QUEUE_DEPTH);
   assign empty     = (cnt_ff == '0);
   assign head_item = slot_ff[rd_ff];

endmodule

// File: hdl/pbp_back.sv
module pbp_back import pbp_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    queue_empty,
   input  pbp_item_type            item,
   output logic                    pop,
   output logic                    rsp_valid,
   output logic [PTR_FIELD_W-1:0]  rsp_blk_ptr,
   output logic                    rsp_from_pool,
   output logic [ALIGN_W-1:0]      rsp_aligned_bytes,
   output logic [BUCKET_OUT_W-1:0] rsp_bucket_num,
   output logic [STATUS_W-1:0]     rsp_status
);

   typedef enum logic [1:0] {
      ST_ACCESS = 2'b01,
      ST_REPLY  = 2'b10
   } back_state_type;

   back_state_type        state_ff, state_in;
   logic [HEAD_W-1:0]     head_ff [NUM_CLASSES];
   logic [CNT_W-1:0]      count_ff [NUM_CLASSES];
   logic [HEAD_W-1:0]     head_in;
   logic [CNT_W-1:0]      count_in;
   logic                  bucket_we;

   logic                  hit_ff, hit_in;
   logic [ALIGN_W-1:0]    aligned_ff;
   logic [BUCKET_W-1:0]   bucket_ff;
   pbp_status_type        status_ff, status_in;

   logic [HEAD_W-1:0]     cur_head;
   logic [CNT_W-1:0]      cur_count;
   logic [CNT_W:0]        tail_sum;
   logic [HEAD_W-1:0]     tail;
   logic [HEAD_W-1:0]     slot;
   logic                  ram_we;
   logic [ADDR_W-1:0]     ram_addr;
   logic [PTR_FIELD_W-1:0] ram_rdata;

   assign cur_head  = head_ff[item.bucket];
   assign cur_count = count_ff[item.bucket];

   always_comb begin
      tail_sum = (CNT_W+1)'(cur_head) + (CNT_W+1)'(cur_count);
      if (int'(tail_sum) >= POOL_DEPTH) begin
         tail_sum = tail_sum - (CNT_W+1)'(POOL_DEPTH);
      end
      tail = HEAD_W'(tail_sum);
   end

   always_comb begin
      state_in  = state_ff;
      pop       = 1'b0;
      hit_in    = 1'b0;
      status_in = STATUS_OK;
      bucket_we = 1'b0;
      head_in   = cur_head;
      count_in  = cur_count;
      ram_we    = 1'b0;
      slot      = cur_head;
      case (state_ff)
         ST_ACCESS: begin
            if (!queue_empty) begin
               pop      = 1'b1;
               state_in = ST_REPLY;
               if (item.oversize) begin
                  status_in = STATUS_TOO_BIG;
               end else if (item.func == FUNC_ALLOC) begin
                  if (cur_count != '0) begin
                     hit_in    = 1'b1;
                     bucket_we = 1'b1;
                     head_in   = (int'(cur_head) == POOL_DEPTH - 1) ?
                                 '0 : cur_head + HEAD_W'(1);
                     count_in  = cur_count - CNT_W'(1);
                  end
               end else begin
                  if (int'(cur_count) >= POOL_DEPTH) begin
                     status_in = STATUS_DROPPED;
                  end else begin
                     bucket_we = 1'b1;
                     ram_we    = 1'b1;
                     slot      = tail;
                     count_in  = cur_count + CNT_W'(1);
                  end
               end
            end
         end
         ST_REPLY: begin
            state_in = ST_ACCESS;
         end
         default: begin
            state_in = ST_ACCESS;
         end
      endcase
      ram_addr = ADDR_W'(int'(item.bucket) * POOL_DEPTH + int'(slot));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACCESS;
         for (int i = 0; i < NUM_CLASSES; i++) begin
            head_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (bucket_we) begin
            head_ff[item.bucket]  <= head_in;
            count_ff[item.bucket] <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         hit_ff     <= hit_in;
         status_ff  <= status_in;
         aligned_ff <= item.aligned;
         bucket_ff  <= item.bucket;
      end
   end

   pbp_ram #(
      .WIDTH (PTR_FIELD_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (item.ptr),
      .rdata (ram_rdata)
   );

   assign rsp_valid         = (state_ff == ST_REPLY);
   assign rsp_blk_ptr       = hit_ff ? ram_rdata : '0;
   assign rsp_from_pool     = hit_ff;
   assign rsp_aligned_bytes = aligned_ff;
   assign rsp_bucket_num    = BUCKET_OUT_W'(bucket_ff);
   assign rsp_status        = status_ff;

endmodule

// File: hdl/pbp_checker.sv
module pbp_checker import pbp_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_valid,
   input logic [PTR_FIELD_W-1:0]  rsp_blk_ptr,
   input logic                    rsp_from_pool,
   input logic [ALIGN_W-1:0]      rsp_aligned_bytes,
   input logic [BUCKET_OUT_W-1:0] rsp_bucket_num,
   input logic [STATUS_W-1:0]     rsp_status
);

   // Each request passes through the access state and then the reply state, so strobes never touch.
   a_strobe_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("two result strobes in a row");

   a_aligned_pow2: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot(rsp_aligned_bytes))
      else $error("aligned size is not a power of two");

   a_hit_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_from_pool |-> rsp_status == STATUS_OK)
      else $error("pool hit with a non-ok status");

   a_miss_null: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_from_pool |-> rsp_blk_ptr == '0)
      else $error("non-zero pointer without a pool hit");

   a_too_big: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_TOO_BIG |-> rsp_bucket_num == '0 && !rsp_from_pool)
      else $error("oversized request reports a bucket or a hit");

endmodule

bind pow2_bucket_block_pool pbp_checker u_checker (.*);

// File: tb/tb_pow2_bucket_block_pool.sv
`timescale 1ns / 1ps

// Testbench for the power-of-two block pool. Requests go in through the start/busy
// command port, and every transfer is predicted on the spot by a model of the bucket
// FIFOs kept in this file. Each result strobe is checked field by field against the
// oldest pending reply. The run opens with a short table of hand-picked requests,
// then moves on to random traffic. The random part fills buckets to their depth and beyond and
// drains them again, so that drops and misses come up as well as hits.
module tb_pow2_bucket_block_pool;
   import pbp_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int TRAFFIC_ROUNDS = 12;
   // The last rounds run with no gaps on the request side.
   localparam int QUIET_ROUNDS   = 2;
   localparam int MIXED_ITEMS    = 58;

   localparam logic [ALIGN_W-1:0] MIN_BLOCK      = ALIGN_W'(1) << MIN_SHIFT;
   localparam logic [ALIGN_W-1:0] MAX_BLOCK      = ALIGN_W'(1) << MAX_SHIFT;
   localparam logic [ALIGN_W-1:0] OVERSIZE_BLOCK = ALIGN_W'(1) << SIZE_W;
   localparam logic [BUCKET_OUT_W-1:0] TOP_BUCKET = BUCKET_OUT_W'(NUM_CLASSES - 1);

   typedef struct packed {
      logic [PTR_FIELD_W-1:0]  blk;
      logic                    from_pool;
      logic [ALIGN_W-1:0]      aligned;
      logic [BUCKET_OUT_W-1:0] bucket;
      pbp_status_type          status;
   } pool_reply_type;

   // One row of the directed table. When typed is set, the reply is written out by hand
   // and is what the result must match; otherwise the prediction is used.
   typedef struct packed {
      pbp_func_type           func;
      logic [SIZE_W-1:0]      bytes;
      logic [PTR_FIELD_W-1:0] ptr;
      logic                   typed;
      pool_reply_type         reply;
   } pool_row_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic                    req_func = 1'b0;
   logic [SIZE_W-1:0]       req_req_bytes = '0;
   logic [PTR_FIELD_W-1:0]  req_ret_ptr = '0;
   logic                    rsp_valid;
   logic [PTR_FIELD_W-1:0]  rsp_blk_ptr;
   logic                    rsp_from_pool;
   logic [ALIGN_W-1:0]      rsp_aligned_bytes;
   logic [BUCKET_OUT_W-1:0] rsp_bucket_num;
   logic [STATUS_W-1:0]     rsp_status;

   // Model of the pool: the cached pointers and the FIFO head and fill of each bucket.
   logic [PTR_FIELD_W-1:0] cached_ptr [NUM_CLASSES][POOL_DEPTH];
   int unsigned            fifo_head [NUM_CLASSES];
   int unsigned            fifo_fill [NUM_CLASSES];

   pool_reply_type pending_replies [$];
   pool_row_type   directed_rows [$];
   int             mismatch_count = 0;
   int             idle_cycles = 0;
   // Chance of a gap before a request is 1 in gap_odds; zero means no gaps at all.
   int             gap_odds = 0;

   always #10 clock = ~clock;

   pow2_bucket_block_pool uut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_func          (req_func),
      .req_req_bytes     (req_req_bytes),
      .req_ret_ptr       (req_ret_ptr),
      .rsp_valid         (rsp_valid),
      .rsp_blk_ptr       (rsp_blk_ptr),
      .rsp_from_pool     (rsp_from_pool),
      .rsp_aligned_bytes (rsp_aligned_bytes),
      .rsp_bucket_num    (rsp_bucket_num),
      .rsp_status        (rsp_status)
   );

   // Works out the reply to one request and applies its effect to the bucket FIFOs.
   // The size is rounded up to a power of two no smaller than the minimum block; a size
   // beyond the largest block leaves every FIFO untouched.
   function automatic pool_reply_type predict_pool_reply(input pbp_func_type f,
         input logic [SIZE_W-1:0] bytes, input logic [PTR_FIELD_W-1:0] ptr);
      pool_reply_type r;
      int             shift;
      int             b;
      int             slot;
      r = '0;
      r.status = STATUS_OK;
      shift = MIN_SHIFT;
      while (shift < 63 && (64'd1 << shift) < 64'(bytes)) begin
         shift++;
      end
      r.aligned = ALIGN_W'(64'd1 << shift);
      if (shift > MAX_SHIFT) begin
         r.status = STATUS_TOO_BIG;
         return r;
      end
      b = shift - MIN_SHIFT;
      r.bucket = BUCKET_OUT_W'(b);
      if (f == FUNC_ALLOC) begin
         // An allocate takes the oldest cached pointer, or misses on an empty bucket.
         if (fifo_fill[b] != 0) begin
            r.blk = cached_ptr[b][fifo_head[b]];
            r.from_pool = 1'b1;
            fifo_head[b] = (fifo_head[b] + 1) % POOL_DEPTH;
            fifo_fill[b]--;
         end
      end else if (fifo_fill[b] >= POOL_DEPTH) begin
         // A free into a full bucket loses its pointer.
         r.status = STATUS_DROPPED;
      end else begin
         slot = (fifo_head[b] + fifo_fill[b]) % POOL_DEPTH;
         cached_ptr[b][slot] = ptr & PTR_MASK;
         fifo_fill[b]++;
      end
      return r;
   endfunction

   // A size that rounds into bucket b, with extra weight on both edges of its range.
   function automatic logic [SIZE_W-1:0] bytes_for_bucket(input int b);
      logic [31:0] top;
      logic [31:0] bottom;
      top = 32'd1 << (b + MIN_SHIFT);
      bottom = (b == 0) ? 32'd0 : (top >> 1) + 32'd1;
      case ($urandom_range(0, 3))
         0: return SIZE_W'(top);
         1: return SIZE_W'(bottom);
         default: return SIZE_W'($urandom_range(bottom, top));
      endcase
   endfunction

   function automatic logic [PTR_FIELD_W-1:0] random_ptr();
      case ($urandom_range(0, 15))
         0: return '0;
         1: return '1;
         default: return PTR_FIELD_W'({$urandom(), $urandom()});
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
         input logic [63:0] want);
      $display("%0t: %s: got %h, expected %h", $time, what, got, want);
      mismatch_count++;
   endtask

   // Drives one request and holds it until the block takes it. A random gap may come
   // first. The reply is predicted at the very edge of the transfer, so the model
   // always sees requests in the order in which the block accepted them.
   task automatic send_request(input pbp_func_type f, input logic [SIZE_W-1:0] bytes,
         input logic [PTR_FIELD_W-1:0] ptr, input logic typed,
         input pool_reply_type typed_reply);
      pool_reply_type predicted;
      if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      start         <= 1'b1;
      req_func      <= f;
      req_req_bytes <= bytes;
      req_ret_ptr   <= ptr;
      do @(posedge clock); while (busy !== 1'b0);
      predicted = predict_pool_reply(f, bytes, ptr);
      pending_replies.push_back(typed ? typed_reply : predicted);
   endtask

   // Mostly sizes of the three smallest buckets, so that hits are common, plus zero
   // sizes and oversized requests.
   task automatic send_random_item();
      int                b;
      logic [SIZE_W-1:0] bytes;
      b = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 2) : $urandom_range(0, NUM_CLASSES - 1);
      case ($urandom_range(0, 19))
         0: bytes = '0;
         1: bytes = SIZE_W'($urandom_range(32'h80_0001, 32'hFF_FFFF));
         default: bytes = bytes_for_bucket(b);
      endcase
      send_request(pbp_func_type'($urandom_range(0, 1)), bytes, random_ptr(), 1'b0, '0);
   endtask

   // Pushes one bucket to its depth or past it, then drains it to empty or past it. Random requests to
   // other buckets are mixed in now and then.
   task automatic fill_then_drain(input int b);
      int n;
      n = POOL_DEPTH + $urandom_range(0, 6);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            send_random_item();
         end
         send_request(FUNC_FREE, bytes_for_bucket(b), random_ptr(), 1'b0, '0);
      end
      n = POOL_DEPTH + $urandom_range(0, 6);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            send_random_item();
         end
         send_request(FUNC_ALLOC, bytes_for_bucket(b), random_ptr(), 1'b0, '0);
      end
   endtask

   task automatic wait_for_replies();
      start <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
   endtask

   task automatic add_row(input pbp_func_type f, input logic [SIZE_W-1:0] bytes,
         input logic [PTR_FIELD_W-1:0] ptr, input logic typed, input pool_reply_type reply);
      directed_rows.push_back(pool_row_type'{f, bytes, ptr, typed, reply});
   endtask

   // Every result strobe is one transfer; it must match the oldest pending reply.
   always @(posedge clock) begin : check_replies
      pool_reply_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_replies.size() == 0) begin
            report_mismatch("result with no request pending", 64'(rsp_blk_ptr), 64'd0);
         end else begin
            want = pending_replies.pop_front();
            if (rsp_blk_ptr !== want.blk)
               report_mismatch("blk_ptr", 64'(rsp_blk_ptr), 64'(want.blk));
            if (rsp_from_pool !== want.from_pool)
               report_mismatch("from_pool", 64'(rsp_from_pool), 64'(want.from_pool));
            if (rsp_aligned_bytes !== want.aligned)
               report_mismatch("aligned_bytes", 64'(rsp_aligned_bytes), 64'(want.aligned));
            if (rsp_bucket_num !== want.bucket)
               report_mismatch("bucket_num", 64'(rsp_bucket_num), 64'(want.bucket));
            if (rsp_status !== want.status)
               report_mismatch("status", 64'(rsp_status), 64'(want.status));
         end
      end
   end

   // The watchdog restarts on every transfer in either direction.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_pow2_bucket_block_pool NOT OK");
         $finish;
      end
   end

   initial begin
      pool_row_type row;
      for (int b = 0; b < NUM_CLASSES; b++) begin
         fifo_head[b] = 0;
         fifo_fill[b] = 0;
      end

      // Right after reset every bucket is empty, so the first allocates miss. Oversized
      // requests are rejected for both functions and leave the pool alone. The top bucket
      // is filled and emptied at its exact bounds, and bucket 0 takes the zero size and
      // keeps its pointers in order of arrival.
      add_row(FUNC_ALLOC, 24'h00_0000, 48'h0, 1'b1,
              pool_reply_type'{48'h0, 1'b0, MIN_BLOCK, 4'd0, STATUS_OK});
      add_row(FUNC_ALLOC, 24'hFF_FFFF, 48'h0, 1'b1,
              pool_reply_type'{48'h0, 1'b0, OVERSIZE_BLOCK, 4'd0, STATUS_TOO_BIG});
      add_row(FUNC_FREE, 24'hFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1,
              pool_reply_type'{48'h0, 1'b0, OVERSIZE_BLOCK, 4'd0, STATUS_TOO_BIG});
      add_row(FUNC_ALLOC, 24'h80_0001, 48'h0, 1'b1,
              pool_reply_type'{48'h0, 1'b0, OVERSIZE_BLOCK, 4'd0, STATUS_TOO_BIG});
      add_row(FUNC_ALLOC, 24'h80_0000, 48'h0, 1'b1,
              pool_reply_type'{48'h0, 1'b0, MAX_BLOCK, TOP_BUCKET, STATUS_OK});
      add_row(FUNC_FREE, 24'h80_0000, 48'hFFFF_FFFF_FFFF, 1'b1,
              pool_reply_type'{48'h0, 1'b0, MAX_BLOCK, TOP_BUCKET, STATUS_OK});
      add_row(FUNC_FREE, 24'h7F_FFFF, 48'h8000_0000_0001, 1'b1,
              pool_reply_type'{48'h0, 1'b0, MAX_BLOCK, TOP_BUCKET, STATUS_OK});
      add_row(FUNC_ALLOC, 24'h40_0001, 48'h0, 1'b1,
              pool_reply_type'{48'hFFFF_FFFF_FFFF, 1'b1, MAX_BLOCK, TOP_BUCKET, STATUS_OK});
      add_row(FUNC_ALLOC, 24'h80_0000, 48'h0, 1'b1,
              pool_reply_type'{48'h8000_0000_0001, 1'b1, MAX_BLOCK, TOP_BUCKET, STATUS_OK});
      add_row(FUNC_ALLOC, 24'h80_0000, 48'h0, 1'b1,
              pool_reply_type'{48'h0, 1'b0, MAX_BLOCK, TOP_BUCKET, STATUS_OK});
      add_row(FUNC_FREE, 24'h00_0000, 48'h0, 1'b1,
              pool_reply_type'{48'h0, 1'b0, MIN_BLOCK, 4'd0, STATUS_OK});
      add_row(FUNC_FREE, 24'h00_0001, 48'h0000_0000_0100, 1'b1,
              pool_reply_type'{48'h0, 1'b0, MIN_BLOCK, 4'd0, STATUS_OK});
      add_row(FUNC_FREE, 24'h00_0100, 48'hAAAA_AAAA_AAAA, 1'b1,
              pool_reply_type'{48'h0, 1'b0, MIN_BLOCK, 4'd0, STATUS_OK});
      add_row(FUNC_ALLOC, 24'h00_0101, 48'h0, 1'b1,
              pool_reply_type'{48'h0, 1'b0, MIN_BLOCK << 1, 4'd1, STATUS_OK});
      add_row(FUNC_ALLOC, 24'h00_00FF, 48'h0, 1'b1,
              pool_reply_type'{48'h0, 1'b1, MIN_BLOCK, 4'd0, STATUS_OK});
      add_row(FUNC_ALLOC, 24'h00_0080, 48'h0, 1'b1,
              pool_reply_type'{48'h0000_0000_0100, 1'b1, MIN_BLOCK, 4'd0, STATUS_OK});
      add_row(FUNC_ALLOC, 24'h00_0001, 48'h5555_5555_5555, 1'b1,
              pool_reply_type'{48'hAAAA_AAAA_AAAA, 1'b1, MIN_BLOCK, 4'd0, STATUS_OK});
      add_row(FUNC_ALLOC, 24'h00_0000, 48'h0, 1'b1,
              pool_reply_type'{48'h0, 1'b0, MIN_BLOCK, 4'd0, STATUS_OK});
      // Middle buckets, with sizes just on either side of a power of two.
      add_row(FUNC_FREE, 24'h00_FFFF, 48'h5555_5555_5555, 1'b0, '0);
      add_row(FUNC_FREE, 24'h01_0001, 48'h1234_5678_9ABC, 1'b0, '0);
      add_row(FUNC_ALLOC, 24'h00_C000, 48'h0, 1'b0, '0);
      add_row(FUNC_ALLOC, 24'h01_FFFF, 48'h0, 1'b0, '0);
      add_row(FUNC_FREE, 24'h00_0FFF, 48'hFFFF_0000_FFFF, 1'b0, '0);
      add_row(FUNC_ALLOC, 24'h00_0801, 48'h0, 1'b0, '0);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      gap_odds = 3;
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         send_request(row.func, row.bytes, row.ptr, row.typed, row.reply);
      end
      // Let the block run dry before the random traffic starts.
      wait_for_replies();

      // Fill-and-drain rounds take turns with mixed traffic. The gap rate changes from
      // round to round, with some rounds free of gaps, and the block runs dry once more
      // halfway through.
      for (int round = 0; round < TRAFFIC_ROUNDS; round++) begin
         gap_odds = (round >= TRAFFIC_ROUNDS - QUIET_ROUNDS) ? 0 : $urandom_range(0, 4);
         if (round % 2 == 0) begin
            fill_then_drain($urandom_range(0, NUM_CLASSES - 1));
         end else begin
            for (int i = 0; i < MIXED_ITEMS; i++) begin
               send_random_item();
            end
         end
         if (round == TRAFFIC_ROUNDS / 2) begin
            wait_for_replies();
         end
      end

      // Drain, then let a stray result show up before the verdict.
      wait_for_replies();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_pow2_bucket_block_pool OK");
      end else begin
         $display("tb_pow2_bucket_block_pool NOT OK");
      end
      $finish;
   end

endmodule

// File: pow2_bucket_block_pool.f
hdl/pbp_pkg.sv
hdl/pbp_ram.sv
hdl/pbp_front.sv
hdl/pbp_queue.sv
hdl/pbp_back.sv
hdl/pow2_bucket_block_pool.sv
hdl/pbp_checker.sv
tb/tb_pow2_bucket_block_pool.sv
